// ===== rtl/core/dd_odo_pkg.sv =====
// ----------------------------------------------------------------------------
// dd_odo_pkg
// shared types, constants and tables of the two-wheel odometry core
// ----------------------------------------------------------------------------
package dd_odo_pkg;

    // serial multiplier: 64-bit multiplicand, 32-bit multiplier
    localparam int MUL_AW = 64;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // serial divider: 64-bit operands, shift up to 63, step count up to 127
    localparam int DIV_W   = 64;
    localparam int DIV_SHW = 6;
    localparam int DIV_CW  = 7;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_PER_TICK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_WIDTH     = 1'b1;

    localparam logic [1:0] KIND_UPDATE      = 2'd0;
    localparam logic [1:0] KIND_START       = 2'd1;
    localparam logic [1:0] KIND_SET_HEADING = 2'd2;

    localparam logic signed [63:0] ONE_Q30        = 64'sd1073741824;
    localparam logic [31:0]        CORDIC_GAIN    = 32'd652032874;
    localparam logic [31:0]        INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic [63:0]        I64_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [MUL_PW-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   num;
        logic [DIV_SHW-1:0] sh;
        logic [DIV_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // atan(2^-i) in binary angle units, 2^32 per turn
    function automatic logic [29:0] atan_entry(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41721;
            5'd15: v = 30'd20860;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2607;
            5'd19: v = 30'd1303;
            5'd20: v = 30'd651;
            5'd21: v = 30'd325;
            5'd22: v = 30'd162;
            5'd23: v = 30'd81;
            5'd24: v = 30'd40;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd2;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/dd_odo_mul.sv =====
// ----------------------------------------------------------------------------
// dd_odo_mul
// bit-serial unsigned multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module dd_odo_mul
    import dd_odo_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    localparam int CNT_W = $clog2(MUL_BW + 1);

    logic [MUL_AW-1:0] a_reg;
    logic [MUL_BW-1:0] b_reg;
    logic [MUL_PW-1:0] acc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MUL_AW:0]   part_next;

    // add the multiplicand into the upper half, then shift right one bit
    assign part_next = {1'b0, acc_reg[MUL_PW-1:MUL_BW]}
                     + (b_reg[0] ? {1'b0, a_reg} : {(MUL_AW+1){1'b0}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_BW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= {part_next, acc_reg[MUL_BW-1:1]};
            b_reg   <= b_reg >> 1;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ===== rtl/core/dd_odo_div.sv =====
// ----------------------------------------------------------------------------
// dd_odo_div
// bit-serial restoring divider, floor(num * 2^sh / den) saturated to 2^63-1
// ----------------------------------------------------------------------------
module dd_odo_div
    import dd_odo_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]  num_reg;
    logic [DIV_W-1:0]  den_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic              sat_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_CW-1:0] last_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff_next;
    logic              fits;

    // one numerator bit enters the partial remainder per cycle
    assign shifted   = {rem_reg, num_reg[DIV_W-1]};
    assign diff_next = shifted - {1'b0, den_reg};
    assign fits      = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == last_reg) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg  <= req.num;
            den_reg  <= req.den;
            rem_reg  <= '0;
            quo_reg  <= '0;
            sat_reg  <= 1'b0;
            last_reg <= DIV_CW'(DIV_W - 1) + DIV_CW'(req.sh);
        end else if (busy_reg) begin
            num_reg <= num_reg << 1;
            rem_reg <= fits ? diff_next[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            sat_reg <= sat_reg | (|quo_reg[DIV_W-1:DIV_W-2]);
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = (sat_reg || quo_reg[DIV_W-1]) ? I64_MAX : quo_reg;

endmodule

// ===== rtl/core/differential_drive_odometry_top.sv =====
// one item is in flight at a time; s_tready is high only in the idle state, so
//   a new item is taken only after the last result is loaded for output
// the serial multiplier and the divider, one quotient bit per cycle over
//   64 + shift steps, are shared by the compute steps of an update
// reset: synchronous active-low aresetn clears pose, heading, previous counts,
//   handshake state and loads the register defaults
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// pose tracking from two tracking-wheel encoder counts, arc model, fixed point
// ----------------------------------------------------------------------------
module differential_drive_odometry_top
    import dd_odo_pkg::*;
#(
    parameter int CORDIC_STEPS  = 24,
    parameter int POS_FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [95:0]          s_tdata,   // right_count, left_count, heading_in
    input  logic [1:0]           s_tuser,   // kind
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [127:0]         m_tdata,   // pos_x, pos_y, heading_out
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int CIT_W    = $clog2(CORDIC_STEPS + 1);
    localparam int SCALE_SH = 32 - POS_FRAC_BITS;
    localparam logic [DIV_SHW-1:0] TH_SH   = DIV_SHW'(48 - POS_FRAC_BITS);
    localparam logic [DIV_SHW-1:0] FACT_SH = DIV_SHW'(32);
    localparam logic signed [63:0] POS_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] POS_MIN = -64'sh0000_8000_0000_0000;

    typedef enum logic [4:0] {
        S_IDLE, S_HCOR, S_SCALE_R, S_SCALE_L, S_ARC, S_TH, S_BAM, S_ACOR,
        S_FS, S_FC, S_LX, S_LY, S_ROT_XC, S_ROT_XS, S_ROT_YC, S_ROT_YS,
        S_COMMIT, S_OUT
    } state_t;

    // control and architectural state
    state_t      state_reg;
    logic        run_reg;          // unit launched, waiting for its finish
    logic        m_tvalid_reg;
    logic [31:0] lpt_reg;
    logic [31:0] tw_reg;
    logic [31:0] prev_r_reg;
    logic [31:0] prev_l_reg;
    logic signed [47:0] pose_x_reg;
    logic signed [47:0] pose_y_reg;
    logic [31:0] heading_reg;

    // working registers of one update
    logic [31:0]        r_in_reg;
    logic [31:0]        l_in_reg;
    logic signed [63:0] dr_reg;
    logic signed [63:0] dl_reg;
    logic signed [63:0] cen_reg;
    logic signed [63:0] diff_reg;
    logic [63:0]        th_reg;
    logic [31:0]        bam_reg;
    logic signed [31:0] hc_reg;
    logic signed [31:0] hs_reg;
    logic signed [31:0] cs_reg;
    logic signed [31:0] sn_reg;
    logic signed [31:0] fs_reg;
    logic signed [31:0] fc_reg;
    logic signed [63:0] lx_reg;
    logic signed [63:0] ly_reg;
    logic signed [63:0] accx_reg;
    logic signed [63:0] accy_reg;
    logic [127:0]       m_tdata_reg;

    // cordic iteration registers
    logic signed [33:0] cx_reg;
    logic signed [33:0] cy_reg;
    logic signed [32:0] cz_reg;
    logic               cneg_reg;
    logic [CIT_W-1:0]   cit_reg;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic is_mul, is_div, is_cor;
    logic unit_done;
    logic out_load;

    dd_odo_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    dd_odo_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd1073741824) begin
            r = 32'sd1073741824;
        end else if (v < -34'sd1073741824) begin
            r = -32'sd1073741824;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > POS_MAX) begin
            r = POS_MAX[47:0];
        end else if (v < POS_MIN) begin
            r = POS_MIN[47:0];
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    // which shared unit the current state drives
    always_comb begin
        is_mul = 1'b0;
        is_div = 1'b0;
        is_cor = 1'b0;
        unique case (state_reg) inside
            S_SCALE_R, S_SCALE_L, S_BAM, S_LX, S_LY,
            S_ROT_XC, S_ROT_XS, S_ROT_YC, S_ROT_YS: is_mul = 1'b1;
            S_TH, S_FS, S_FC:                       is_div = 1'b1;
            S_HCOR, S_ACOR:                         is_cor = 1'b1;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- ticks
    // count delta against the stored count, 34 bits so it cannot wrap
    logic [31:0]        tick_cur, tick_prev;
    logic signed [33:0] tick_d;
    logic [32:0]        tick_mag;
    logic [63:0]        scale_p;
    logic signed [63:0] scale_val;

    assign tick_cur  = (state_reg == S_SCALE_R) ? r_in_reg   : l_in_reg;
    assign tick_prev = (state_reg == S_SCALE_R) ? prev_r_reg : prev_l_reg;
    assign tick_d    = signed'({{2{tick_cur[31]}}, tick_cur})
                     - signed'({{2{tick_prev[31]}}, tick_prev});
    assign tick_mag  = tick_d[33] ? 33'(-tick_d) : tick_d[32:0];
    assign scale_p   = mul_rsp.product[SCALE_SH +: 64];
    assign scale_val = tick_d[33] ? -signed'(scale_p) : signed'(scale_p);

    // ------------------------------------------------------- q30 products
    logic signed [63:0] qa;
    logic signed [31:0] qf;
    logic [63:0]        qa_mag;
    logic [31:0]        qf_mag;
    logic               q_neg;
    logic [64:0]        q30_p;
    logic [63:0]        q30_mag;
    logic signed [63:0] q30_val;

    always_comb begin
        case (state_reg)
            S_LX:     begin qa = cen_reg; qf = fc_reg; end
            S_LY:     begin qa = cen_reg; qf = fs_reg; end
            S_ROT_XC: begin qa = lx_reg;  qf = hc_reg; end
            S_ROT_XS: begin qa = ly_reg;  qf = hs_reg; end
            S_ROT_YC: begin qa = ly_reg;  qf = hc_reg; end
            default:  begin qa = lx_reg;  qf = hs_reg; end
        endcase
    end

    assign qa_mag  = qa[63] ? 64'(-qa) : 64'(qa);
    assign qf_mag  = qf[31] ? 32'(-qf) : 32'(qf);
    assign q_neg   = qa[63] ^ qf[31];
    // product magnitude truncated by 2^30, clamped to the int64 range
    assign q30_p   = mul_rsp.product[94:30];
    assign q30_mag = (|q30_p[64:63]) ? I64_MAX : q30_p[63:0];
    assign q30_val = q_neg ? -signed'(q30_mag) : signed'(q30_mag);

    // multiplier operand selection
    always_comb begin
        mul_req.start = is_mul && !run_reg;
        case (state_reg)
            S_SCALE_R, S_SCALE_L: begin
                mul_req.a = {31'd0, tick_mag};
                mul_req.b = lpt_reg;
            end
            S_BAM: begin
                mul_req.a = th_reg;
                mul_req.b = INV_TWO_PI_Q32;
            end
            default: begin
                mul_req.a = qa_mag;
                mul_req.b = qf_mag;
            end
        endcase
    end

    // binary angle of the heading change, bits [63:32] of th * (2^32 / 2pi)
    logic [31:0] bam_m;
    assign bam_m = mul_rsp.product[63:32];

    // --------------------------------------------------------- divisions
    logic [31:0]        sn_mag;
    logic [30:0]        fact_mag;
    logic signed [31:0] fact_pos;

    assign sn_mag = sn_reg[31] ? 32'(-sn_reg) : 32'(sn_reg);

    always_comb begin
        div_req.start = is_div && !run_reg;
        case (state_reg)
            S_TH: begin
                div_req.num = diff_reg[63] ? 64'(-diff_reg) : 64'(diff_reg);
                div_req.sh  = TH_SH;
                div_req.den = (tw_reg == 32'd0) ? 64'd1 : {32'd0, tw_reg};
            end
            S_FS: begin
                div_req.num = {32'd0, sn_mag};
                div_req.sh  = FACT_SH;
                div_req.den = th_reg;
            end
            default: begin
                div_req.num = 64'(ONE_Q30 - 64'(cs_reg));
                div_req.sh  = FACT_SH;
                div_req.den = th_reg;
            end
        endcase
    end

    // arc factors saturate at 1.0
    assign fact_mag = (div_rsp.quotient > 64'd1073741824) ? 31'd1073741824
                                                          : div_rsp.quotient[30:0];
    assign fact_pos = signed'({1'b0, fact_mag});

    // ------------------------------------------------------------ cordic
    // fold the angle into +-quarter turn, remember the half-turn flip
    logic [31:0]        cor_ang;
    logic signed [32:0] z0;
    logic signed [32:0] z_pre;
    logic               neg_pre;
    logic [4:0]         ish;
    logic signed [33:0] cdx, cdy;
    logic signed [32:0] cat;
    logic               cor_fin;
    logic signed [31:0] cor_x, cor_y;

    assign cor_ang = (state_reg == S_HCOR) ? heading_reg : bam_reg;
    assign z0      = signed'({cor_ang[31], cor_ang});

    always_comb begin
        z_pre   = z0;
        neg_pre = 1'b0;
        if (z0 > 33'sd1073741824) begin
            z_pre   = z0 - 33'sd2147483648;
            neg_pre = 1'b1;
        end else if (z0 < -33'sd1073741824) begin
            z_pre   = z0 + 33'sd2147483648;
            neg_pre = 1'b1;
        end
    end

    assign ish     = 5'(cit_reg);
    assign cdx     = cy_reg >>> ish;
    assign cdy     = cx_reg >>> ish;
    assign cat     = signed'({3'b000, atan_entry(ish)});
    assign cor_fin = (cit_reg == CIT_W'(CORDIC_STEPS));
    assign cor_x   = clamp_one(cneg_reg ? -cx_reg : cx_reg);
    assign cor_y   = clamp_one(cneg_reg ? -cy_reg : cy_reg);

    // ----------------------------------------------------------- control
    always_comb begin
        unit_done = 1'b0;
        if (run_reg) begin
            if (is_mul) begin
                unit_done = mul_rsp.done;
            end else if (is_div) begin
                unit_done = div_rsp.done;
            end else if (is_cor) begin
                unit_done = cor_fin;
            end
        end
    end

    assign out_load  = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // state machine, architectural state and register bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            run_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            lpt_reg      <= 32'd103071816;
            tw_reg       <= 32'd476267;
            prev_r_reg   <= '0;
            prev_l_reg   <= '0;
            pose_x_reg   <= '0;
            pose_y_reg   <= '0;
            heading_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_LENGTH_PER_TICK: lpt_reg <= cfg_data;
                    CFG_TRACK_WIDTH:     tw_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // result transaction taken with no new result behind it
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        unique case (s_tuser)
                            KIND_UPDATE: state_reg <= S_HCOR;
                            KIND_START: begin
                                pose_x_reg  <= '0;
                                pose_y_reg  <= '0;
                                heading_reg <= '0;
                                prev_r_reg  <= s_tdata[31:0];
                                prev_l_reg  <= s_tdata[63:32];
                                state_reg   <= S_OUT;
                            end
                            KIND_SET_HEADING: begin
                                heading_reg <= s_tdata[95:64];
                                prev_r_reg  <= '0;
                                prev_l_reg  <= '0;
                                state_reg   <= S_OUT;
                            end
                            default: state_reg <= S_OUT;   // unused kind reports pose
                        endcase
                    end
                end
                S_ARC: state_reg <= S_TH;
                S_COMMIT: begin
                    pose_x_reg  <= sat48(accx_reg);
                    pose_y_reg  <= sat48(accy_reg);
                    heading_reg <= heading_reg + bam_reg;
                    prev_r_reg  <= r_in_reg;
                    prev_l_reg  <= l_in_reg;
                    state_reg   <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    // shared-unit steps: launch, then wait for the finish
                    if (!run_reg) begin
                        run_reg <= 1'b1;
                    end else if (unit_done) begin
                        run_reg <= 1'b0;
                        unique case (state_reg)
                            S_HCOR:    state_reg <= S_SCALE_R;
                            S_SCALE_R: state_reg <= S_SCALE_L;
                            S_SCALE_L: state_reg <= S_ARC;
                            S_TH: begin
                                // straight move skips the arc factors
                                state_reg <= (div_rsp.quotient == 64'd0) ? S_ROT_XC
                                                                         : S_BAM;
                            end
                            S_BAM:     state_reg <= S_ACOR;
                            S_ACOR:    state_reg <= S_FS;
                            S_FS:      state_reg <= S_FC;
                            S_FC:      state_reg <= S_LX;
                            S_LX:      state_reg <= S_LY;
                            S_LY:      state_reg <= S_ROT_XC;
                            S_ROT_XC:  state_reg <= S_ROT_XS;
                            S_ROT_XS:  state_reg <= S_ROT_YC;
                            S_ROT_YC:  state_reg <= S_ROT_YS;
                            default:   state_reg <= S_COMMIT;
                        endcase
                    end
                end
            endcase
        end
    end

    // working datapath registers
    logic signed [63:0] cen_sum;
    assign cen_sum = dr_reg + dl_reg;

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            r_in_reg <= s_tdata[31:0];
            l_in_reg <= s_tdata[63:32];
        end

        // cordic: load on launch, one micro-rotation per cycle
        if (is_cor && !run_reg) begin
            cx_reg   <= signed'({2'b00, CORDIC_GAIN});
            cy_reg   <= '0;
            cz_reg   <= z_pre;
            cneg_reg <= neg_pre;
            cit_reg  <= '0;
        end else if (is_cor && !cor_fin) begin
            if (!cz_reg[32]) begin
                cx_reg <= cx_reg - cdx;
                cy_reg <= cy_reg + cdy;
                cz_reg <= cz_reg - cat;
            end else begin
                cx_reg <= cx_reg + cdx;
                cy_reg <= cy_reg - cdy;
                cz_reg <= cz_reg + cat;
            end
            cit_reg <= cit_reg + 1'b1;
        end

        if (state_reg == S_ARC) begin
            // centre arc truncates toward zero
            cen_reg  <= (cen_sum + signed'({63'd0, cen_sum[63]})) >>> 1;
            diff_reg <= dr_reg - dl_reg;
        end

        if (unit_done) begin
            case (state_reg)
                S_HCOR: begin
                    hc_reg <= cor_x;
                    hs_reg <= cor_y;
                end
                S_SCALE_R: dr_reg <= scale_val;
                S_SCALE_L: dl_reg <= scale_val;
                S_TH: begin
                    th_reg  <= div_rsp.quotient;
                    lx_reg  <= '0;
                    ly_reg  <= -cen_reg;
                    bam_reg <= '0;
                end
                S_BAM:  bam_reg <= diff_reg[63] ? -bam_m : bam_m;
                S_ACOR: begin
                    cs_reg <= cor_x;
                    sn_reg <= cor_y;
                end
                S_FS: fs_reg <= (sn_reg[31] != diff_reg[63]) ? -fact_pos : fact_pos;
                S_FC: fc_reg <= diff_reg[63] ? -fact_pos : fact_pos;
                S_LX: lx_reg <= -q30_val;
                S_LY: ly_reg <= -q30_val;
                S_ROT_XC: accx_reg <= 64'(pose_x_reg) + q30_val;
                S_ROT_XS: accx_reg <= accx_reg + q30_val;
                S_ROT_YC: accy_reg <= 64'(pose_y_reg) + q30_val;
                S_ROT_YS: accy_reg <= accy_reg - q30_val;
                default: ;
            endcase
        end

        if (out_load) begin
            m_tdata_reg <= {heading_reg, pose_y_reg, pose_x_reg};
        end
    end

`ifndef SYNTHESIS
    // a start item leaves the pose and heading cleared
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_START)
        |=> (pose_x_reg == '0 && pose_y_reg == '0 && heading_reg == '0))
        else $error("start transaction did not clear the pose");

    // a waiting result is never overwritten by the next one
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_tvalid_reg && !m_tready) |=> (state_reg == S_OUT))
        else $error("result register reloaded while a transaction is pending");

    // no shared unit is in flight outside the compute steps
    a_run_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_OUT || state_reg == S_COMMIT
         || state_reg == S_ARC) |-> !run_reg)
        else $error("unit running outside a compute step");
`endif

endmodule

// ===== sim/differential_drive_odometry_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_top_tb
// self-checking bench: a behavioral pose tracker predicts every result
// transaction, the monitor compares pose and heading field by field, across
// several register settings with random idling on both streams
// ----------------------------------------------------------------------------
module differential_drive_odometry_top_tb;
    import dd_odo_pkg::*;

    localparam int      CLK_HALF   = 4;
    localparam longint  CYCLE_MAX  = 64'd8000000;
    localparam int      DRAIN_WAIT = 800;
    localparam longint  Q30        = 64'sd1073741824;
    localparam longint  POS_HI     = (64'sd1 <<< 47) - 1;
    localparam longint  POS_LO     = -(64'sd1 <<< 47);
    localparam bit [63:0] SAT63    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam bit [63:0] TURN_INV = 64'd683565276;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam bit [31:0] ARC_TAN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162,
        81, 40, 20, 10, 5, 2, 1, 0, 0
    };

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] right;
        logic [31:0] left;
        logic [31:0] hdg;
    } odo_item_t;

    typedef struct {
        logic [47:0] x;
        logic [47:0] y;
        logic [31:0] h;
    } pose_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [95:0]          s_tdata;   // right_count, left_count, heading_in
    logic [1:0]           s_tuser;   // kind
    logic                 m_tvalid;
    logic                 m_tready;
    logic [127:0]         m_tdata;   // pos_x, pos_y, heading_out
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    odo_item_t pending_items[$];
    pose_t     pose_expected[$];
    int        errors;
    int        idle_pct;
    longint    cycle_count = 0;

    // tracker copy of registers and state
    bit [31:0] trk_lpt;
    bit [31:0] trk_tw;
    bit [31:0] trk_prev_r;
    bit [31:0] trk_prev_l;
    longint    trk_x;
    longint    trk_y;
    bit [31:0] trk_hdg;

    // generator's view of the encoder counts
    bit [31:0] enc_r;
    bit [31:0] enc_l;

    differential_drive_odometry_top dut (.*);

    always begin
        aclk = 1'b1;
        #CLK_HALF;
        aclk = 1'b0;
        #CLK_HALF;
    end

    // ------------------------------------------------------------------
    // fixed-point pose tracker
    // ------------------------------------------------------------------
    function automatic bit [63:0] magn(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    // floor(num * 2^sh / den), saturated to 2^63-1
    function automatic bit [63:0] div_scaled(bit [63:0] num, int sh, bit [63:0] den);
        bit [63:0] q;
        bit [63:0] r;
        bit [63:0] b;
        bit        sat;
        q = 0;
        r = 0;
        sat = 0;
        if (den == 0) return SAT63;
        for (int k = 0; k < 64 + sh; k++) begin
            b = (k < 64) ? ((num >> (63 - k)) & 64'd1) : 64'd0;
            r = (r << 1) | b;
            if ((q >> 62) != 0) sat = 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return (sat || q > SAT63) ? SAT63 : q;
    endfunction

    // a * f / 2^30, magnitude truncated
    function automatic longint mul_frac(longint a, longint f);
        bit        neg;
        bit [63:0] ma;
        bit [63:0] mf;
        bit [63:0] p;
        neg = (a < 0) != (f < 0);
        ma = magn(a);
        mf = magn(f);
        p = (ma >> 30) * mf + (((ma & 64'h3FFF_FFFF) * mf) >> 30);
        if (p > SAT63) p = SAT63;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint clip_unit(longint v);
        if (v > Q30) return Q30;
        if (v < -Q30) return -Q30;
        return v;
    endfunction

    function automatic longint clip_pos(longint v);
        if (v > POS_HI) return POS_HI;
        if (v < POS_LO) return POS_LO;
        return v;
    endfunction

    task automatic rotate_unit(input bit [31:0] ang, output longint cs, output longint sn);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = longint'({32'd0, ang});
        x = longint'({32'd0, CORDIC_GAIN});
        y = 0;
        flip = 0;
        if (z >= (64'sd1 <<< 31)) z = z - (64'sd1 <<< 32);
        // fold into the right half-plane
        if (z > Q30) begin
            z = z - (64'sd1 <<< 31);
            flip = 1;
        end else if (z < -Q30) begin
            z = z + (64'sd1 <<< 31);
            flip = 1;
        end
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'({32'd0, ARC_TAN[i]});
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'({32'd0, ARC_TAN[i]});
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = clip_unit(x);
        sn = clip_unit(y);
    endtask

    function automatic longint ticks_to_inches(longint d);
        bit [63:0] p;
        p = (magn(d) * {32'd0, trk_lpt}) >> 16;
        return d < 0 ? -longint'(p) : longint'(p);
    endfunction

    task automatic track_pose(input odo_item_t it);
        longint    dr;
        longint    dl;
        longint    cen;
        longint    diff;
        longint    lx;
        longint    ly;
        longint    cs;
        longint    sn;
        longint    hc;
        longint    hs;
        longint    fs;
        longint    fc;
        bit [63:0] tw;
        bit [63:0] th;
        bit [31:0] m;
        bit [31:0] bam;
        pose_t     res;
        case (it.kind)
            KIND_UPDATE: begin
                dr = longint'(signed'(it.right)) - longint'(signed'(trk_prev_r));
                dl = longint'(signed'(it.left)) - longint'(signed'(trk_prev_l));
                dr = ticks_to_inches(dr);
                dl = ticks_to_inches(dl);
                cen = (dr + dl) / 2;
                diff = dr - dl;
                tw = (trk_tw != 0) ? {32'd0, trk_tw} : 64'd1;
                th = div_scaled(magn(diff), 32, tw);
                lx = 0;
                ly = -cen;
                bam = 0;
                // zero radian change means a straight move
                if (th != 0) begin
                    m = 32'((th >> 32) * TURN_INV + (((th & 64'hFFFF_FFFF) * TURN_INV) >> 32));
                    bam = diff < 0 ? 32'd0 - m : m;
                    rotate_unit(bam, cs, sn);
                    fs = longint'(div_scaled(magn(sn), 32, th));
                    if (fs > Q30) fs = Q30;
                    if ((sn < 0) != (diff < 0)) fs = -fs;
                    fc = longint'(div_scaled(64'(Q30 - cs), 32, th));
                    if (fc > Q30) fc = Q30;
                    if (diff < 0) fc = -fc;
                    lx = -mul_frac(cen, fc);
                    ly = -mul_frac(cen, fs);
                end
                rotate_unit(trk_hdg, hc, hs);
                trk_x = clip_pos(trk_x + mul_frac(lx, hc) + mul_frac(ly, hs));
                trk_y = clip_pos(trk_y + mul_frac(ly, hc) - mul_frac(lx, hs));
                trk_hdg = trk_hdg + bam;
                trk_prev_r = it.right;
                trk_prev_l = it.left;
            end
            KIND_START: begin
                trk_x = 0;
                trk_y = 0;
                trk_hdg = 0;
                trk_prev_r = it.right;
                trk_prev_l = it.left;
            end
            KIND_SET_HEADING: begin
                trk_hdg = it.hdg;
                trk_prev_r = 0;
                trk_prev_l = 0;
            end
            default: ;
        endcase
        res.x = trk_x[47:0];
        res.y = trk_y[47:0];
        res.h = trk_hdg;
        pose_expected.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // driver: input transactions from the pending queue
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_pose('{s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]});
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    odo_item_t it;
                    it = pending_items.pop_front();
                    s_tuser  <= it.kind;
                    s_tdata  <= {it.hdg, it.left, it.right};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: result transactions against the oldest expected pose
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= idle_pct);
            if (m_tvalid && m_tready) begin
                if (pose_expected.size() == 0) begin
                    $error("result transaction with no pose expected");
                    errors++;
                end else begin
                    pose_t e;
                    e = pose_expected.pop_front();
                    if (m_tdata[47:0] !== e.x) begin
                        $error("pos_x expected %h actual %h", e.x, m_tdata[47:0]);
                        errors++;
                    end
                    if (m_tdata[95:48] !== e.y) begin
                        $error("pos_y expected %h actual %h", e.y, m_tdata[95:48]);
                        errors++;
                    end
                    if (m_tdata[127:96] !== e.h) begin
                        $error("heading_out expected %h actual %h", e.h, m_tdata[127:96]);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX) begin
            $display("differential_drive_odometry_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic add_item(logic [1:0] k, logic [31:0] r, logic [31:0] l, logic [31:0] h);
        pending_items.push_back('{k, r, l, h});
        if (k == KIND_UPDATE || k == KIND_START) begin
            enc_r = r;
            enc_l = l;
        end else if (k == KIND_SET_HEADING) begin
            enc_r = 0;
            enc_l = 0;
        end
    endtask

    function automatic bit [31:0] step_count(bit [31:0] base);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return base + 32'(signed'($urandom_range(0, 4000)) - 2000);
        if (sel < 80) return base + 32'(signed'($urandom_range(0, 2097152)) - 1048576);
        if (sel < 92) return $urandom;
        return base;
    endfunction

    task automatic random_items(int n);
        int sel;
        bit [31:0] d;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 15) begin
                // both wheels move the same amount
                d = 32'(signed'($urandom_range(0, 20000)) - 10000);
                add_item(KIND_UPDATE, enc_r + d, enc_l + d, $urandom);
            end else if (sel < 85) begin
                add_item(KIND_UPDATE, step_count(enc_r), step_count(enc_l), $urandom);
            end else if (sel < 90) begin
                add_item(KIND_START, $urandom, $urandom, $urandom);
            end else if (sel < 95) begin
                add_item(KIND_SET_HEADING, $urandom, $urandom, $urandom);
            end else begin
                add_item(KIND_UNUSED, $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_LENGTH_PER_TICK) trk_lpt = val;
        else trk_tw = val;
        @(posedge aclk);
    endtask

    task automatic run_phase(logic [31:0] lpt, logic [31:0] tw, int pct, int n);
        // register writes only once every earlier transaction is done
        while (pending_items.size() != 0 || s_tvalid || pose_expected.size() != 0)
            @(posedge aclk);
        write_reg(CFG_LENGTH_PER_TICK, lpt);
        write_reg(CFG_TRACK_WIDTH, tw);
        idle_pct = pct;
        random_items(n);
        while (pending_items.size() != 0 || s_tvalid || pose_expected.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        errors      = 0;
        idle_pct    = 31;
        enc_r       = 0;
        enc_l       = 0;
        trk_lpt     = 32'd103071816;
        trk_tw      = 32'd476267;
        trk_prev_r  = 0;
        trk_prev_l  = 0;
        trk_x       = 0;
        trk_y       = 0;
        trk_hdg     = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset registers, count extremes, every kind
        add_item(KIND_UPDATE, 32'd0, 32'd0, 32'd0);
        add_item(KIND_UPDATE, 32'd100, 32'd100, 32'd0);
        add_item(KIND_UPDATE, 32'd1000, 32'd100, 32'd0);
        add_item(KIND_UPDATE, 32'd1001, 32'd101, 32'd0);
        add_item(KIND_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        add_item(KIND_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        add_item(KIND_START, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        add_item(KIND_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
        add_item(KIND_SET_HEADING, 32'd5, 32'd7, 32'hFFFF_FFFF);
        add_item(KIND_UPDATE, 32'd500, 32'hFFFF_FE0C, 32'd0);
        add_item(KIND_SET_HEADING, 32'd0, 32'd0, 32'h8000_0000);
        add_item(KIND_UPDATE, 32'd300, 32'd900, 32'd0);
        add_item(KIND_SET_HEADING, 32'd0, 32'd0, 32'h4000_0000);
        add_item(KIND_UPDATE, 32'd2000, 32'd2000, 32'd0);
        add_item(KIND_SET_HEADING, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hC000_0000);
        add_item(KIND_UPDATE, 32'd1, 32'd0, 32'd0);
        add_item(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(KIND_START, 32'd0, 32'd0, 32'd0);
        add_item(KIND_UPDATE, 32'h8000_0000, 32'h8000_0000, 32'd0);
        add_item(KIND_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);

        run_phase(32'd103071816, 32'd476267, 31, 300);
        // saturation corner: full travel per tick, narrowest track
        run_phase(32'hFFFF_FFFF, 32'd1, 31, 150);
        // no travel at all
        run_phase(32'd0, 32'hFFFF_FFFF, 31, 100);
        // stretch with no idling on either side
        run_phase($urandom, $urandom_range(65536, 32'h0100_0000), 0, 300);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31, 150);
        run_phase(32'd103071816, 32'd476267, 31, 400);

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0 && pose_expected.size() == 0) begin
            $display("differential_drive_odometry_top test passed");
        end else begin
            $display("differential_drive_odometry_top test failed");
        end
        $finish;
    end

endmodule

// ===== differential_drive_odometry_top.f =====
rtl/core/dd_odo_pkg.sv
rtl/core/dd_odo_mul.sv
rtl/core/dd_odo_div.sv
rtl/core/differential_drive_odometry_top.sv
sim/differential_drive_odometry_top_tb.sv
